[hw/rtl/adk_pkg.sv]
// Shared types and constants for the ADC ladder key press detector.
`default_nettype none

package adk_pkg;

  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned HOLD_BITS   = 8;
  localparam int unsigned CFG_DATA_W  = (SAMPLE_BITS > HOLD_BITS) ? SAMPLE_BITS : HOLD_BITS;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [HOLD_BITS-1:0] HOLD_MAX = {HOLD_BITS{1'b1}};

  localparam logic [SAMPLE_BITS-1:0] NONE_MIN_RST = SAMPLE_BITS'(860);
  localparam logic [SAMPLE_BITS-1:0] UP_MIN_RST   = SAMPLE_BITS'(608);
  localparam logic [SAMPLE_BITS-1:0] LEFT_MIN_RST = SAMPLE_BITS'(359);
  localparam logic [SAMPLE_BITS-1:0] DOWN_MIN_RST = SAMPLE_BITS'(121);
  localparam logic [HOLD_BITS-1:0]   LONG_RST     = HOLD_BITS'(10);

  typedef enum logic [2:0] {
    KEY_NONE  = 3'd0,
    KEY_UP    = 3'd1,
    KEY_LEFT  = 3'd2,
    KEY_DOWN  = 3'd3,
    KEY_RIGHT = 3'd4
  } key_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_LONG  = 2'd1,
    EV_SHORT = 2'd2
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NONE_MIN   = 3'd0,
    REG_UP_MIN     = 3'd1,
    REG_LEFT_MIN   = 3'd2,
    REG_DOWN_MIN   = 3'd3,
    REG_LONG_TICKS = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] none_min;
    logic [SAMPLE_BITS-1:0] up_min;
    logic [SAMPLE_BITS-1:0] left_min;
    logic [SAMPLE_BITS-1:0] down_min;
    logic [HOLD_BITS-1:0]   long_ticks;
  } cfg_t;

endpackage

`default_nettype wire

[hw/rtl/adk_if.sv]
// Request and result channel interfaces of the key press detector.
`default_nettype none

interface adk_req_if import adk_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   read_ok;

  modport source (output valid, output sample, output read_ok, input ready);
  modport sink   (input valid, input sample, input read_ok, output ready);
endinterface

interface adk_res_if import adk_pkg::*; ();
  logic   valid;
  logic   ready;
  key_e   held_key;
  event_e event_res;
  key_e   event_key;

  modport source (output valid, output held_key, output event_res, output event_key,
                  input ready);
  modport sink   (input valid, input held_key, input event_res, input event_key,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/adc_ladder_key_press_detector.sv]
// Top level of the ADC ladder keypad detector with debounce and long/short press.
// Flow: an accepted request is held in the input register and moves into the result
// register once that register is empty or its result is being taken.
// Throughput: one request per cycle while results are taken; input and result registers
// part the channels, so one more request is taken while a result waits.
// Reset: thresholds and long press count return to defaults, no key held,
// both pipeline registers empty.
`default_nettype none

module adc_ladder_key_press_detector import adk_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  adk_req_if.sink                    req_i,
  adk_res_if.source                  res_o
);

  cfg_t                   cfg;
  logic                   req_vld_q, res_vld_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   read_ok_q;
  logic                   adv;
  key_e                   key;

  assign adv         = req_vld_q && (!res_vld_q || res_o.ready);
  assign req_i.ready = !req_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        req_vld_q <= req_i.valid;
      end
      if (adv) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      sample_q  <= req_i.sample;
      read_ok_q <= req_i.read_ok;
    end
  end

  adk_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  adk_decode u_decode (
    .sample_i (sample_q),
    .cfg_i    (cfg),
    .key_o    (key)
  );

  adk_track u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .read_ok_i    (read_ok_q),
    .key_i        (key),
    .long_ticks_i (cfg.long_ticks),
    .held_key_o   (res_o.held_key),
    .event_res_o  (res_o.event_res),
    .event_key_o  (res_o.event_key)
  );

  assign res_o.valid = res_vld_q;

endmodule

`default_nettype wire

[hw/rtl/adk_cfg.sv]
// Configuration register file: ladder thresholds and long press count.
`default_nettype none

module adk_cfg import adk_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_NONE_MIN:   cfg_d.none_min   = cfg_data_i[SAMPLE_BITS-1:0];
        REG_UP_MIN:     cfg_d.up_min     = cfg_data_i[SAMPLE_BITS-1:0];
        REG_LEFT_MIN:   cfg_d.left_min   = cfg_data_i[SAMPLE_BITS-1:0];
        REG_DOWN_MIN:   cfg_d.down_min   = cfg_data_i[SAMPLE_BITS-1:0];
        REG_LONG_TICKS: cfg_d.long_ticks = cfg_data_i[HOLD_BITS-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.none_min   <= NONE_MIN_RST;
      cfg_q.up_min     <= UP_MIN_RST;
      cfg_q.left_min   <= LEFT_MIN_RST;
      cfg_q.down_min   <= DOWN_MIN_RST;
      cfg_q.long_ticks <= LONG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hw/rtl/adk_decode.sv]
// Sorts one ladder sample into a key code by the threshold registers.
`default_nettype none

module adk_decode import adk_pkg::*; (
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire cfg_t                   cfg_i,
  output key_e                        key_o
);

  // first threshold that holds wins, even when unordered
  always_comb begin
    if (sample_i >= cfg_i.none_min) begin
      key_o = KEY_NONE;
    end else if (sample_i >= cfg_i.up_min) begin
      key_o = KEY_UP;
    end else if (sample_i >= cfg_i.left_min) begin
      key_o = KEY_LEFT;
    end else if (sample_i >= cfg_i.down_min) begin
      key_o = KEY_DOWN;
    end else begin
      key_o = KEY_RIGHT;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/adk_track.sv]
// Debounce, hold counting and press event state with the result register.
`default_nettype none

module adk_track import adk_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 adv_i,
  input  wire logic                 read_ok_i,
  input  wire key_e                 key_i,
  input  wire logic [HOLD_BITS-1:0] long_ticks_i,
  output key_e                      held_key_o,
  output event_e                    event_res_o,
  output key_e                      event_key_o
);

  key_e                 confirmed_q, confirmed_d;
  key_e                 previous_q, previous_d;
  logic [HOLD_BITS-1:0] hold_q, hold_d;
  logic [HOLD_BITS-1:0] hold_inc;
  event_e               ev_d, ev_q;
  key_e                 ev_key_d, ev_key_q, held_q;

  assign hold_inc = hold_q + HOLD_BITS'(1);

  always_comb begin
    confirmed_d = confirmed_q;
    previous_d  = previous_q;
    hold_d      = hold_q;
    ev_d        = EV_NONE;
    ev_key_d    = KEY_NONE;
    if (read_ok_i) begin
      previous_d = key_i;
      if (confirmed_q == KEY_NONE) begin
        if (key_i != KEY_NONE && key_i == previous_q) begin
          confirmed_d = key_i;
          hold_d      = '0;
        end
      end else if (key_i == confirmed_q) begin
        if (hold_q != HOLD_MAX) begin
          hold_d = hold_inc;
          if (hold_inc == long_ticks_i) begin
            ev_d     = EV_LONG;
            ev_key_d = confirmed_q;
          end
        end
      end else if (key_i == KEY_NONE) begin
        if (hold_q < long_ticks_i) begin
          ev_d     = EV_SHORT;
          ev_key_d = confirmed_q;
        end
        confirmed_d = KEY_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      confirmed_q <= KEY_NONE;
      previous_q  <= KEY_NONE;
      hold_q      <= '0;
    end else if (adv_i) begin
      confirmed_q <= confirmed_d;
      previous_q  <= previous_d;
      hold_q      <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      held_q   <= confirmed_d;
      ev_q     <= ev_d;
      ev_key_q <= ev_key_d;
    end
  end

  assign held_key_o  = held_q;
  assign event_res_o = ev_q;
  assign event_key_o = ev_key_q;

endmodule

`default_nettype wire
